>>> hdl/lxc_pkg.sv
// Shared types, constants and constant functions for the LCG XOR stream cipher.
package lxc_pkg;

    localparam logic [31:0] LCG_MUL    = 32'd1103515245;
    localparam logic [31:0] LCG_ADD    = 32'd12345;
    localparam logic [31:0] SEED_MUL   = 32'd31;
    localparam int          SKIP_COUNT = 8;
    localparam int          MAX_KEY_BYTES = 16;
    localparam int          WORD_BYTES = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE   = 2'd2;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [63:0] sequence_number;
        logic        first_of_message;
        logic        last_of_message;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
    } out_t;

    // Settings seen by the datapath
    typedef struct packed {
        logic [31:0] key_seed;
        logic        enable;
    } cfg_t;

    typedef struct packed {
        logic [31:0] mul;
        logic [31:0] add;
    } affine_t;

    // 31^n mod 2^32
    function automatic logic [31:0] seed_pow(input int n);
        logic [31:0] p;
        p = 32'd1;
        for (int i = 0; i < MAX_KEY_BYTES; i++)
        begin
            if (i < n)
                p = p * SEED_MUL;
        end
        return p;
    endfunction

    // Contribution of one 64-bit key word (bytes base..base+7) to the folded seed
    function automatic logic [31:0] key_fold(input logic [63:0] word, input int base,
                                             input int nbytes);
        logic [31:0] acc;
        logic [7:0]  kb;
        acc = '0;
        for (int j = 0; j < WORD_BYTES; j++)
        begin
            kb = word[63 - 8*j -: 8];
            if (base + j < nbytes)
                acc = acc + seed_pow(nbytes - 1 - base - j) * {24'd0, kb};
        end
        return acc;
    endfunction

    // Affine map for the skip plus the first keystream step
    function automatic affine_t lcg_jump(input int steps);
        affine_t t;
        t.mul = 32'd1;
        t.add = 32'd0;
        for (int i = 0; i < SKIP_COUNT + 1; i++)
        begin
            if (i < steps)
            begin
                t.mul = t.mul * LCG_MUL;
                t.add = t.add * LCG_MUL + LCG_ADD;
            end
        end
        return t;
    endfunction

    localparam affine_t FIRST_JUMP = lcg_jump(SKIP_COUNT + 1);

endpackage

>>> hdl/lcg_xor_stream_cipher_unit.sv
// Top level of the LCG keystream XOR cipher.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------
//  in       | input     | in_valid/in_stall   | in_data  (lxc_pkg::in_t)
//  out      | output    | out_valid/out_stall | out_data (lxc_pkg::out_t)
//  cfg      | input     | cfg_we              | cfg_index, cfg_wdata
//
// One byte per cycle sustained while out_stall is low; a request passes the
// input and result registers. The generator step is one 32x32 multiply and add
// on the registered request; seed, eight-step skip and first step form one map.
// Reset clears the generator state, key and enable; the block is ready at once.
// in_stall rises only while a request is held and the result register is stalled.
module lcg_xor_stream_cipher_unit #(
    parameter int KEY_BYTES = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lxc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lxc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  lxc_pkg::in_t                     in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output lxc_pkg::out_t                    out_data
);

    lxc_pkg::cfg_t cfg;

    lxc_cfg #(
        .KEY_BYTES (KEY_BYTES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lxc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> hdl/lxc_cfg.sv
// Configuration registers with the session key pre-folded into a seed.
module lxc_cfg #(
    parameter int KEY_BYTES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lxc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lxc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output lxc_pkg::cfg_t                      cfg
);

    logic [31:0] hi_fold_reg, hi_fold_next;
    logic [31:0] lo_fold_reg, lo_fold_next;
    logic [31:0] key_seed_reg, key_seed_next;
    logic        enable_reg, enable_next;
    logic [31:0] wr_hi_fold;
    logic [31:0] wr_lo_fold;

    assign wr_hi_fold = lxc_pkg::key_fold(cfg_wdata, 0, KEY_BYTES);
    assign wr_lo_fold = lxc_pkg::key_fold(cfg_wdata, lxc_pkg::WORD_BYTES, KEY_BYTES);

    // Keep the full seed ready so the datapath never adds the halves
    always_comb
    begin
        hi_fold_next  = hi_fold_reg;
        lo_fold_next  = lo_fold_reg;
        key_seed_next = key_seed_reg;
        enable_next   = enable_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                lxc_pkg::REG_KEY_HIGH:
                begin
                    hi_fold_next  = wr_hi_fold;
                    key_seed_next = wr_hi_fold + lo_fold_reg;
                end
                lxc_pkg::REG_KEY_LOW:
                begin
                    lo_fold_next  = wr_lo_fold;
                    key_seed_next = hi_fold_reg + wr_lo_fold;
                end
                lxc_pkg::REG_ENABLE:
                begin
                    enable_next = cfg_wdata[0];
                end
                default:
                begin
                    enable_next = enable_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_fold_reg  <= '0;
            lo_fold_reg  <= '0;
            key_seed_reg <= '0;
            enable_reg   <= 1'b0;
        end
        else
        begin
            hi_fold_reg  <= hi_fold_next;
            lo_fold_reg  <= lo_fold_next;
            key_seed_reg <= key_seed_next;
            enable_reg   <= enable_next;
        end
    end

    assign cfg.key_seed = key_seed_reg;
    assign cfg.enable   = enable_reg;

endmodule

>>> hdl/lxc_core.sv
// Request pipeline: input register, generator step and result register.
module lxc_core (
    input  logic           clk,
    input  logic           rst_n,
    input  lxc_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_stall,
    input  lxc_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output lxc_pkg::out_t  out_data
);

    logic          s1_valid_reg, s1_valid_next;
    lxc_pkg::in_t  s1_item_reg;
    logic          out_valid_reg, out_valid_next;
    lxc_pkg::out_t out_item_reg;
    logic [31:0]   lcg_state_reg, lcg_state_next;

    logic          out_free;
    logic          s1_adv;
    logic          in_accept;
    logic [31:0]   step_x;
    logic [31:0]   step_mul;
    logic [31:0]   step_add;
    logic [31:0]   step_state;
    lxc_pkg::out_t result;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // First byte: seed, skip and first step fold into one affine map
    always_comb
    begin
        if (s1_item_reg.first_of_message)
        begin
            step_x   = cfg.key_seed ^ s1_item_reg.sequence_number[31:0]
                       ^ s1_item_reg.sequence_number[63:32];
            step_mul = lxc_pkg::FIRST_JUMP.mul;
            step_add = lxc_pkg::FIRST_JUMP.add;
        end
        else
        begin
            step_x   = lcg_state_reg;
            step_mul = lxc_pkg::LCG_MUL;
            step_add = lxc_pkg::LCG_ADD;
        end
        step_state = 32'(step_mul * step_x) + step_add;
    end

    always_comb
    begin
        result.last_out = s1_item_reg.last_of_message;
        if (cfg.enable)
            result.out_byte = s1_item_reg.data_byte ^ step_state[7:0];
        else
            result.out_byte = s1_item_reg.data_byte;
    end

    assign lcg_state_next = (s1_adv && cfg.enable) ? step_state : lcg_state_reg;
    assign s1_valid_next  = in_stall ? s1_valid_reg : in_valid;
    assign out_valid_next = out_free ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lcg_state_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            lcg_state_reg <= lcg_state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_item_reg <= in_data;
        if (s1_adv)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

>>> hdl/lxc_checker.sv
// Port-level checks for the cipher top level, bound to every instance.
module lxc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input lxc_pkg::out_t out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // Stall upstream only when the result register is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output side is free");

    // An accepted request reaches the output when not blocked
    a_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
        else $error("accepted request did not advance");

    // No result without an earlier request
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result appeared without a request");

endmodule

bind lcg_xor_stream_cipher_unit lxc_checker u_lxc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

>>> tb/lcg_xor_stream_cipher_unit_tb.sv
// Testbench for the LCG keystream XOR cipher: directed and random message traffic.
module lcg_xor_stream_cipher_unit_tb;

    localparam int KEY_BYTES   = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 10;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [lxc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [lxc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    lxc_pkg::in_t                    in_data   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    lxc_pkg::out_t                   out_data;

    // Predictor copy of the block's registers and generator
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic        cipher_on;
    logic [31:0] keystream_state;

    lxc_pkg::out_t expected_bytes[$];
    int   idle_pct;
    int   stall_pct;
    int   mismatch_count;
    int   cycle_count;

    lcg_xor_stream_cipher_unit #(
        .KEY_BYTES(KEY_BYTES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] lcg_next(input logic [31:0] s);
        return s * lxc_pkg::LCG_MUL + lxc_pkg::LCG_ADD;
    endfunction

    function automatic logic [31:0] message_seed(input logic [63:0] seq);
        logic [31:0] seed;
        logic [7:0]  kb;
        seed = '0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            kb = (i < 8) ? key_high[63 - 8*i -: 8] : key_low[63 - 8*(i - 8) -: 8];
            seed = seed * lxc_pkg::SEED_MUL + {24'd0, kb};
        end
        return seed ^ seq[31:0] ^ seq[63:32];
    endfunction

    // Advance the generator copy and return the byte the block must produce
    function automatic lxc_pkg::out_t cipher_byte(input lxc_pkg::in_t req);
        lxc_pkg::out_t res;
        logic [31:0]   s;
        res.out_byte = req.data_byte;
        res.last_out = req.last_of_message;
        if (cipher_on)
        begin
            if (req.first_of_message)
            begin
                s = message_seed(req.sequence_number);
                for (int k = 0; k < lxc_pkg::SKIP_COUNT; k++)
                    s = lcg_next(s);
                keystream_state = s;
            end
            keystream_state = lcg_next(keystream_state);
            res.out_byte = req.data_byte ^ keystream_state[7:0];
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: stall at random, the rate set per phase
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        lxc_pkg::out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("Unexpected result: byte %02h last %0b",
                             out_data.out_byte, out_data.last_out);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_data.out_byte !== want.out_byte ||
                    out_data.last_out !== want.last_out)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("Mismatch: byte exp %02h got %02h, last exp %0b got %0b",
                                 want.out_byte, out_data.out_byte,
                                 want.last_out, out_data.last_out);
                end
            end
        end
    end

    // Hold the request until taken, then record what it must produce
    task automatic send_request(input lxc_pkg::in_t req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_bytes.push_back(cipher_byte(req));
    endtask

    task automatic send_byte(input logic [7:0] data, input logic [63:0] seq,
                             input logic first, input logic last);
        lxc_pkg::in_t req;
        req.data_byte        = data;
        req.sequence_number  = seq;
        req.first_of_message = first;
        req.last_of_message  = last;
        send_request(req);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lxc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            lxc_pkg::REG_KEY_HIGH: key_high = val;
            lxc_pkg::REG_KEY_LOW:  key_low = val;
            lxc_pkg::REG_ENABLE:   cipher_on = val[0];
            default: ;
        endcase
    endtask

    // Only called with the block drained
    task automatic configure(input logic [63:0] hi, input logic [63:0] lo, input logic en);
        write_reg(lxc_pkg::REG_KEY_HIGH, hi);
        write_reg(lxc_pkg::REG_KEY_LOW, lo);
        write_reg(lxc_pkg::REG_ENABLE, {63'd0, en});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_reset_defaults();
        // disabled after reset: first byte must not reseed
        send_byte(8'hA5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        send_byte(8'h00, 64'd0, 1'b0, 1'b1);
        wait_for_results();
        // zero key, no first byte yet: continue from the reset state
        configure(64'd0, 64'd0, 1'b1);
        send_byte(8'h00, 64'd0, 1'b0, 1'b0);
        send_byte(8'hFF, 64'd0, 1'b0, 1'b1);
        send_byte(8'h5A, 64'd0, 1'b1, 1'b0);
        send_byte(8'h00, 64'd0, 1'b0, 1'b1);
        wait_for_results();
    endtask

    task automatic test_directed_cases();
        configure(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_byte(8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        send_byte(8'hFF, 64'h0, 1'b0, 1'b0);
        send_byte(8'h81, 64'h0, 1'b0, 1'b1);
        // single-byte message
        send_byte(8'hFF, 64'h8000_0000_0000_0001, 1'b1, 1'b1);
        // reseed mid-message
        send_byte(8'h12, 64'h0000_0001_0000_0000, 1'b1, 1'b0);
        send_byte(8'h34, 64'h0, 1'b0, 1'b0);
        send_byte(8'h56, 64'hFFFF_FFFF_0000_0000, 1'b1, 1'b0);
        wait_for_results();
        configure(64'h0102_0304_0506_0708, 64'h090A_0B0C_0D0E_0F10, 1'b1);
        send_byte(8'h3C, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0);
        send_byte(8'hC3, 64'h0, 1'b0, 1'b0);
        wait_for_results();
        // disable mid-message: pass through, generator held
        configure(64'h0102_0304_0506_0708, 64'h090A_0B0C_0D0E_0F10, 1'b0);
        send_byte(8'h3C, 64'hDEAD_BEEF_0000_0001, 1'b1, 1'b0);
        send_byte(8'hF0, 64'h0, 1'b0, 1'b1);
        wait_for_results();
        // re-enable without first: continue the held state
        configure(64'h0102_0304_0506_0708, 64'h090A_0B0C_0D0E_0F10, 1'b1);
        send_byte(8'h0F, 64'h0, 1'b0, 1'b0);
        send_byte(8'h77, 64'h0, 1'b0, 1'b1);
        wait_for_results();
    endtask

    task automatic send_messages(input int count);
        int           left;
        lxc_pkg::in_t req;
        left = 0;
        for (int n = 0; n < count; n++)
        begin
            req.data_byte       = 8'($urandom_range(255));
            req.sequence_number = rand64();
            if ($urandom_range(99) < 12)
            begin
                // noise: loose flags
                req.first_of_message = 1'($urandom_range(1));
                req.last_of_message  = 1'($urandom_range(1));
            end
            else
            begin
                req.first_of_message = (left == 0);
                if (left == 0)
                    left = ($urandom_range(19) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12);
                left--;
                req.last_of_message = (left == 0);
            end
            send_request(req);
        end
    endtask

    task automatic test_pause_for_results();
        configure(rand64(), rand64(), 1'b1);
        send_messages(12);
        // hold off until every result is back, then resume the stream
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        send_messages(12);
        wait_for_results();
    endtask

    task automatic run_phase(input int idle, input int stall, input logic [63:0] hi,
                             input logic [63:0] lo, input logic en, input int count);
        idle_pct  = idle;
        stall_pct = stall;
        configure(hi, lo, en);
        send_messages(count);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        run_phase(0, 0, rand64(), rand64(), 1'b1, 170);
        run_phase(81, 0, 64'd0, 64'd0, 1'b1, 150);
        run_phase(0, 81, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 150);
        run_phase(31, 31, rand64(), rand64(), 1'b0, 60);
        run_phase(31, 31, rand64(), rand64(), 1'b1, 120);
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        key_high        = '0;
        key_low         = '0;
        cipher_on       = 1'b0;
        keystream_state = '0;
        idle_pct        = 0;
        stall_pct       = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_cases();
        test_pause_for_results();
        test_random_traffic();
        wait_for_results();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
